@@ sv/odo_pkg.sv @@
// odometry package: shared types, register indexes and arithmetic helpers
// used by the controller, the datapath and the top level; no dependencies
package odo_pkg;

  localparam int ADDR_W = 5;
  localparam int CIDX_W = 5;
  localparam int ATAN_COUNT = 30;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic [2:0] REG_DIST = 3'd0;
  localparam logic [2:0] REG_RAD  = 3'd1;
  localparam logic [2:0] REG_ISEP = 3'd2;
  localparam logic [2:0] REG_IPER = 3'd3;
  localparam logic [2:0] REG_TURN = 3'd4;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_LO,
    PH_HI,
    PH_ACC,
    PH_FIN
  } phase_t;

  typedef enum logic [3:0] {
    J_LM,
    J_RM,
    J_CM,
    J_DM,
    J_AM,
    J_LS,
    J_RS,
    J_LIN,
    J_ANG,
    J_X,
    J_Y,
    J_H
  } job_t;

  typedef struct packed {
    logic              load_in;
    logic              cord_init;
    logic              cord_step;
    logic [CIDX_W-1:0] cord_idx;
    phase_t            ph;
    job_t              job;
    logic              commit;
  } odo_cmd_t;

  typedef struct packed {
    logic [31:0] dist_per_tick;
    logic [31:0] rad_per_tick;
    logic [31:0] inv_separation;
    logic [31:0] inv_period;
    logic [31:0] turn_per_tick_diff;
  } odo_cfg_t;

  function automatic logic [29:0] atan_val(input logic [CIDX_W-1:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
    return neg ? 32'(-mag) : mag;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] d,
                                          input logic neg);
    logic signed [33:0] r;
    logic [33:0] de;
    de = {1'b0, d};
    r = $signed({{2{a[31]}}, a}) + $signed(neg ? 34'(-de) : de);
    if (!r[33] && (r[32:31] != 2'b00)) return 32'h7FFF_FFFF;
    else if (r[33] && (r[32:31] != 2'b11)) return 32'h8000_0000;
    else return r[31:0];
  endfunction

endpackage

@@ sv/odo_ctrl.sv @@
// odometry controller: one-hot sequencer over the multiply jobs and cordic steps
// depends on odo_pkg
module odo_ctrl import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output odo_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LO   = 6'b000010,
    S_HI   = 6'b000100,
    S_ACC  = 6'b001000,
    S_FIN  = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t            state, state_next;
  job_t              job, job_next;
  logic              cord_run, cord_run_next;
  logic [CIDX_W-1:0] cidx, cidx_next;
  logic              out_valid_next;
  logic              accept, commit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_UPD) && (!out_valid || out_ready);

  always_comb begin
    state_next    = state;
    job_next      = job;
    cord_run_next = cord_run;
    cidx_next     = cidx;
    if (cord_run) begin
      cidx_next = cidx + 1'b1;
      if (cidx == CIDX_W'(CORDIC_STEPS - 1)) cord_run_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next    = S_LO;
          job_next      = J_LM;
          cord_run_next = 1'b1;
          cidx_next     = '0;
        end
      end
      S_LO:  state_next = S_HI;
      S_HI:  state_next = S_ACC;
      S_ACC: state_next = S_FIN;
      S_FIN: begin
        if (job == J_H) begin
          state_next = S_UPD;
        end else begin
          state_next = S_LO;
          job_next   = job_t'(job + 4'd1);
        end
      end
      S_UPD: begin
        if (commit) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      job       <= J_LM;
      cord_run  <= 1'b0;
      cidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      job       <= job_next;
      cord_run  <= cord_run_next;
      cidx      <= cidx_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    cmd.load_in   = accept;
    cmd.cord_init = accept;
    cmd.cord_step = cord_run;
    cmd.cord_idx  = cidx;
    cmd.job       = job;
    cmd.commit    = commit;
    unique case (state)
      S_LO:    cmd.ph = PH_LO;
      S_HI:    cmd.ph = PH_HI;
      S_ACC:   cmd.ph = PH_ACC;
      S_FIN:   cmd.ph = PH_FIN;
      default: cmd.ph = PH_NONE;
    endcase
  end

endmodule

@@ sv/odo_dp.sv @@
// odometry datapath: tick deltas, shared 32x32 multiplier with 96-bit accumulator,
// cordic rotator, pose state and result registers; depends on odo_pkg
module odo_dp import odo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  odo_cmd_t           cmd,
  input  odo_cfg_t           cfg,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic        [31:0] heading,
  output logic signed [31:0] l_wheel_rate,
  output logic signed [31:0] r_wheel_rate,
  output logic signed [31:0] lin_speed,
  output logic signed [31:0] ang_speed
);

  logic [31:0] prev_left, prev_right, x_acc, y_acc, heading_acc;
  logic [31:0] dl_in, dr_in;
  logic signed [31:0] dl, dr;
  logic signed [32:0] sum, diff;
  logic [31:0] dl_mag, dr_mag;
  logic [32:0] sum_mag, diff_mag;
  logic [63:0] lm, rm, cm, dm, am;
  logic [31:0] lsp, rsp, lin, ang, hstep;
  logic [32:0] dx, dy;
  logic signed [33:0] cx, cy, cz, xs, ys;
  logic flip;
  logic signed [33:0] cos_v, sin_v, cos_mag, sin_mag;
  logic [31:0] ang_in, ang_fold;
  logic ang_flip;
  logic [63:0] p;
  logic [95:0] acc, sh;
  logic [63:0] op_a, cap, res;
  logic [31:0] op_b, op_m;
  logic [6:0] shamt;
  logic [31:0] x_new, y_new;

  assign dl_in = left_count - prev_left;
  assign dr_in = right_count - prev_right;

  assign dl_mag   = dl[31] ? 32'(-dl) : 32'(dl);
  assign dr_mag   = dr[31] ? 32'(-dr) : 32'(dr);
  assign sum_mag  = sum[32] ? 33'(-sum) : 33'(sum);
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

  assign cos_v   = flip ? -cx : cx;
  assign sin_v   = flip ? -cy : cy;
  assign cos_mag = cos_v[33] ? -cos_v : cos_v;
  assign sin_mag = sin_v[33] ? -sin_v : sin_v;

  assign ang_in   = heading_acc;
  assign ang_flip = ang_in[31] ^ ang_in[30];
  assign ang_fold = ang_flip ? (ang_in - 32'h8000_0000) : ang_in;
  assign xs = cx >>> cmd.cord_idx;
  assign ys = cy >>> cmd.cord_idx;

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    shamt = 7'd0;
    cap   = '1;
    unique case (cmd.job)
      J_LM:  begin op_a = {32'd0, dl_mag}; op_b = cfg.rad_per_tick; end
      J_RM:  begin op_a = {32'd0, dr_mag}; op_b = cfg.rad_per_tick; end
      J_CM:  begin op_a = {31'd0, sum_mag}; op_b = cfg.dist_per_tick; end
      J_DM:  begin op_a = {31'd0, diff_mag}; op_b = cfg.dist_per_tick; end
      J_AM:  begin op_a = dm; op_b = cfg.inv_separation; shamt = 7'd32; end
      J_LS: begin
        op_a = lm; op_b = cfg.inv_period; shamt = 7'd32;
        cap = dl[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      J_RS: begin
        op_a = rm; op_b = cfg.inv_period; shamt = 7'd32;
        cap = dr[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      J_LIN: begin
        op_a = cm; op_b = cfg.inv_period; shamt = 7'd33;
        cap = sum[32] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      J_ANG: begin
        op_a = am; op_b = cfg.inv_period; shamt = 7'd16;
        cap = diff[32] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      end
      J_X: begin
        op_a = cm; op_b = cos_mag[31:0]; shamt = 7'd47; cap = 64'h1_0000_0000;
      end
      J_Y: begin
        op_a = cm; op_b = sin_mag[31:0]; shamt = 7'd47; cap = 64'h1_0000_0000;
      end
      J_H:   begin op_a = {32'd0, diff[31:0]}; op_b = cfg.turn_per_tick_diff; end
      default: ;
    endcase
  end

  assign op_m = (cmd.ph == PH_HI) ? op_a[63:32] : op_a[31:0];
  assign sh   = acc >> shamt;
  assign res  = ((|sh[95:64]) || (sh[63:0] > cap)) ? cap : sh[63:0];

  assign x_new = sat_add(x_acc, dx, sum[32] ^ cos_v[33]);
  assign y_new = sat_add(y_acc, dy, sum[32] ^ sin_v[33]);

  // multiplier and job results
  always_ff @(posedge clk) begin
    if (cmd.ph == PH_LO || cmd.ph == PH_HI) p <= op_m * op_b;
    if (cmd.ph == PH_HI) acc <= {32'd0, p};
    else if (cmd.ph == PH_ACC) acc <= acc + {p, 32'd0};
    if (cmd.ph == PH_FIN) begin
      unique case (cmd.job)
        J_LM:  lm <= res;
        J_RM:  rm <= res;
        J_CM:  cm <= res;
        J_DM:  dm <= res;
        J_AM:  am <= res;
        J_LS:  lsp <= apply_sign(res[31:0], dl[31]);
        J_RS:  rsp <= apply_sign(res[31:0], dr[31]);
        J_LIN: lin <= apply_sign(res[31:0], sum[32]);
        J_ANG: ang <= apply_sign(res[31:0], diff[32]);
        J_X:   dx <= res[32:0];
        J_Y:   dy <= res[32:0];
        J_H:   hstep <= res[31:0];
        default: ;
      endcase
    end
  end

  // deltas and cordic rotator
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dl   <= dl_in;
      dr   <= dr_in;
      sum  <= {dl_in[31], dl_in} + {dr_in[31], dr_in};
      diff <= {dr_in[31], dr_in} - {dl_in[31], dl_in};
    end
    if (cmd.cord_init) begin
      flip <= ang_flip;
      cx   <= CORDIC_X0;
      cy   <= '0;
      cz   <= 34'($signed(ang_fold));
    end else if (cmd.cord_step) begin
      if (!cz[33]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - $signed({4'd0, atan_val(cmd.cord_idx)});
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + $signed({4'd0, atan_val(cmd.cord_idx)});
      end
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left   <= '0;
      prev_right  <= '0;
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
    end else begin
      if (cmd.load_in) begin
        prev_left  <= left_count;
        prev_right <= right_count;
      end
      if (cmd.commit) begin
        x_acc       <= x_new;
        y_acc       <= y_new;
        heading_acc <= heading_acc + hstep;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pos_x        <= $signed(x_new);
      pos_y        <= $signed(y_new);
      heading      <= heading_acc + hstep;
      l_wheel_rate <= $signed(lsp);
      r_wheel_rate <= $signed(rsp);
      lin_speed    <= $signed(lin);
      ang_speed    <= $signed(ang);
    end
  end

endmodule

@@ sv/diff_drive_wheel_odometry.sv @@
// differential drive odometry top level: configuration registers, controller
// and datapath; depends on odo_pkg, odo_ctrl and odo_dp
//
//   channel  handshake               payload
//   in       in_valid / in_ready     left_count, right_count
//   out      out_valid / out_ready   pos_x, pos_y, heading, l/r_wheel_rate, lin/ang_speed
//   cfg      psel/penable/pwrite     paddr, pwdata, prdata
//
// one item runs twelve multiply jobs on one shared 32x32 multiplier, each job
// stepping through S_LO, S_HI, S_ACC, S_FIN; the cordic runs alongside the first jobs
// a finished result waits in its output register while the next item is taken
// reset is synchronous; pose and previous counts clear to zero
module diff_drive_wheel_odometry import odo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic        [31:0] heading,
  output logic signed [31:0] l_wheel_rate,
  output logic signed [31:0] r_wheel_rate,
  output logic signed [31:0] lin_speed,
  output logic signed [31:0] ang_speed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  odo_cfg_t cfg;
  odo_cmd_t cmd;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dist_per_tick      <= 32'd0;
      cfg.rad_per_tick       <= 32'd0;
      cfg.inv_separation     <= 32'd65536;
      cfg.inv_period         <= 32'd6553600;
      cfg.turn_per_tick_diff <= 32'd0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_DIST: cfg.dist_per_tick      <= pwdata;
        REG_RAD:  cfg.rad_per_tick       <= pwdata;
        REG_ISEP: cfg.inv_separation     <= pwdata;
        REG_IPER: cfg.inv_period         <= pwdata;
        REG_TURN: cfg.turn_per_tick_diff <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_DIST: prdata = cfg.dist_per_tick;
      REG_RAD:  prdata = cfg.rad_per_tick;
      REG_ISEP: prdata = cfg.inv_separation;
      REG_IPER: prdata = cfg.inv_period;
      REG_TURN: prdata = cfg.turn_per_tick_diff;
      default:  prdata = 32'd0;
    endcase
  end

  odo_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  odo_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .left_count  (left_count),
    .right_count (right_count),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .l_wheel_rate(l_wheel_rate),
    .r_wheel_rate(r_wheel_rate),
    .lin_speed   (lin_speed),
    .ang_speed   (ang_speed)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was taken");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an item in work");

  a_accept_starts_jobs: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> cmd.ph == PH_LO && cmd.job == J_LM)
    else $error("job sequence did not start on accept");

endmodule
